FILE: design/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch coordinate calibrator package
// Shared widths, constants, register indexes and pipeline sideband types.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// Raw sample and register widths.
	localparam int RAWW = 16;
	localparam int DENW = 16;
	localparam int PIXW = 16;
	localparam int ORIW = 3;
	localparam int IDXW = 3;

	// Normalized axis range is 0..4095, so the quotient has twelve bits.
	localparam int QW   = 12;
	localparam int NUMW = QW + DENW;

	localparam logic [QW-1:0] FULL_SCALE = 12'hfff;

	// Configuration register indexes.
	localparam logic [IDXW-1:0] REG_X_MIN         = 3'd0;
	localparam logic [IDXW-1:0] REG_X_MAX         = 3'd1;
	localparam logic [IDXW-1:0] REG_Y_MIN         = 3'd2;
	localparam logic [IDXW-1:0] REG_Y_MAX         = 3'd3;
	localparam logic [IDXW-1:0] REG_ORIENTATION   = 3'd4;
	localparam logic [IDXW-1:0] REG_SCREEN_WIDTH  = 3'd5;
	localparam logic [IDXW-1:0] REG_SCREEN_HEIGHT = 3'd6;

	// How an axis value is chosen once the divide is done.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FULL,
		SEL_QUOT
	} sel_t;

	// Control that travels alongside the divider lanes.
	typedef struct packed {
		logic uncal;
		sel_t sel_x;
		sel_t sel_y;
	} side_t;

endpackage

FILE: design/tcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch coordinate calibrator channels
// Valid/ready channels for raw samples and calibrated pixel results.
// ----------------------------------------------------------------------------
interface tcc_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [tcc_pkg::RAWW-1:0]   raw_x;
	logic signed [tcc_pkg::RAWW-1:0]   raw_y;

	modport source (output valid, output raw_x, output raw_y, input ready);
	modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface tcc_out_if;
	logic                       valid;
	logic                       ready;
	logic [tcc_pkg::PIXW-1:0]   pixel_x;
	logic [tcc_pkg::PIXW-1:0]   pixel_y;
	logic                       uncalibrated;

	modport source (output valid, output pixel_x, output pixel_y, output uncalibrated,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input uncalibrated,
		output ready);
endinterface

FILE: design/tcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch coordinate calibrator divider
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tcc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcc_pkg::NUMW-1:0]    in_num [2],
	input  logic [tcc_pkg::DENW-1:0]    in_den [2],
	input  tcc_pkg::side_t              in_side,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcc_pkg::QW-1:0]      out_quot [2],
	output tcc_pkg::side_t              out_side
);

	localparam int QW   = tcc_pkg::QW;
	localparam int NUMW = tcc_pkg::NUMW;
	localparam int DENW = tcc_pkg::DENW;

	// Stages 1..QW are registers; the incoming transaction feeds stage 1.
	logic                 vld_s  [1:QW];
	logic                 rdy    [1:QW+1];
	logic [NUMW-1:0]      rem_s  [1:QW][2];
	logic [DENW-1:0]      den_s  [1:QW][2];
	logic [QW-1:0]        quo_s  [1:QW][2];
	tcc_pkg::side_t       side_s [1:QW];

	assign rdy[QW+1] = out_ready;
	assign in_ready  = rdy[1];

	// Each stage settles one quotient bit, most significant first.
	for (genvar k = 1; k <= QW; k++) begin : g_stage
		localparam int BIT = QW - k;

		logic            vld_p;
		logic [NUMW-1:0] rem_p [2];
		logic [DENW-1:0] den_p [2];
		logic [QW-1:0]   quo_p [2];
		tcc_pkg::side_t  side_p;
		logic [NUMW-1:0] sub [2];
		logic            ge  [2];

		// The first stage is fed from the ports, the others from the stage before.
		if (k == 1) begin : g_head
			always_comb begin
				vld_p  = in_valid;
				side_p = in_side;
				for (int l = 0; l < 2; l++) begin
					rem_p[l] = in_num[l];
					den_p[l] = in_den[l];
					quo_p[l] = '0;
				end
			end
		end else begin : g_body
			always_comb begin
				vld_p  = vld_s[k-1];
				side_p = side_s[k-1];
				for (int l = 0; l < 2; l++) begin
					rem_p[l] = rem_s[k-1][l];
					den_p[l] = den_s[k-1][l];
					quo_p[l] = quo_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sub[l] = NUMW'(den_p[l]) << BIT;
				ge[l]  = rem_p[l] >= sub[l];
			end
		end

		// A stage takes new data when it is empty or its content moves on.
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_p) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l] <= ge[l] ? rem_p[l] - sub[l] : rem_p[l];
					den_s[k][l] <= den_p[l];
					quo_s[k][l] <= quo_p[l] | (QW'(ge[l]) << BIT);
				end
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid   = vld_s[QW];
	assign out_side    = side_s[QW];
	assign out_quot[0] = quo_s[QW][0];
	assign out_quot[1] = quo_s[QW][1];

`ifndef SYNTH
	// With the reading strictly between the limits the quotient stays below full scale.
	a_quot_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_side.uncal && out_side.sel_x == tcc_pkg::SEL_QUOT
		|-> out_quot[0] != tcc_pkg::FULL_SCALE)
		else $error("x quotient reached full scale");

	// A finished divide leaves a remainder below the divisor.
	a_rem_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_side.uncal && out_side.sel_y == tcc_pkg::SEL_QUOT
		|-> rem_s[QW][1] < NUMW'(den_s[QW][1]))
		else $error("y remainder not below divisor");

	// A stalled quotient holds its place until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("divider output dropped during a stall");
`endif

endmodule

FILE: design/touch_coordinate_calibrator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch coordinate calibrator
// Maps raw signed touch readings to display pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   sample  (sink)   : one raw transaction carries raw_x and raw_y.
//   result  (source) : one transaction per sample with pixel_x, pixel_y and
//                      the uncalibrated flag, in sample order.
//   wr_en/wr_index/wr_data : register writes, taken on any edge with wr_en
//                      high; write only while no sample is in flight.
// A sample passes from acceptance to result valid through 16
// register stages: one of limit compares, one forming 4095 times the offset,
// twelve divider stages (one quotient bit each), one for inversion and swap
// and one for the screen-size multiply. Throughput is one sample per cycle
// while the receiver does not stall, as the divider is fully pipelined.
// Every stage has its own valid bit and loads whenever it is empty or its
// content moves on, so bubbles close up while the receiver stalls and a
// sample is accepted as long as any stage ahead has room.
// Reset clears all valid bits and sets every configuration register to zero,
// which makes the block report uncalibrated until limits are written.
// ----------------------------------------------------------------------------
module touch_coordinate_calibrator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	tcc_in_if.sink                         sample,
	tcc_out_if.source                      result,
	input  logic                           wr_en,
	input  logic [tcc_pkg::IDXW-1:0]       wr_index,
	input  logic [tcc_pkg::DENW-1:0]       wr_data
);

	localparam int QW   = tcc_pkg::QW;
	localparam int NUMW = tcc_pkg::NUMW;
	localparam int DENW = tcc_pkg::DENW;
	localparam int RAWW = tcc_pkg::RAWW;
	localparam int PIXW = tcc_pkg::PIXW;
	localparam int ORIW = tcc_pkg::ORIW;

	// Configuration registers.
	logic signed [RAWW-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [ORIW-1:0]        orient_q;
	logic [DENW-1:0]        scr_w_q, scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= '0;
			x_max_q  <= '0;
			y_min_q  <= '0;
			y_max_q  <= '0;
			orient_q <= '0;
			scr_w_q  <= '0;
			scr_h_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				tcc_pkg::REG_X_MIN:         x_min_q  <= wr_data;
				tcc_pkg::REG_X_MAX:         x_max_q  <= wr_data;
				tcc_pkg::REG_Y_MIN:         y_min_q  <= wr_data;
				tcc_pkg::REG_Y_MAX:         y_max_q  <= wr_data;
				tcc_pkg::REG_ORIENTATION:   orient_q <= wr_data[ORIW-1:0];
				tcc_pkg::REG_SCREEN_WIDTH:  scr_w_q  <= wr_data;
				tcc_pkg::REG_SCREEN_HEIGHT: scr_h_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Stage handshake signals.
	logic           v_s1, v_s2, v_s3, v_s4;
	logic           rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic           div_in_ready, div_out_valid;
	logic [QW-1:0]  div_quot [2];
	tcc_pkg::side_t div_side;

	assign rdy_s4       = !v_s4 || result.ready;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || div_in_ready;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;

	// Stage 1: limit compares, offset and span for each axis.
	logic [DENW-1:0] num_x, num_y, den_x, den_y;
	tcc_pkg::sel_t   sel_x, sel_y;
	logic            uncal;

	always_comb begin
		num_x = sample.raw_x - x_min_q;
		num_y = sample.raw_y - y_min_q;
		den_x = x_max_q - x_min_q;
		den_y = y_max_q - y_min_q;
		uncal = (x_min_q == x_max_q) || (y_min_q == y_max_q);
		if (sample.raw_x <= x_min_q) begin
			sel_x = tcc_pkg::SEL_ZERO;
		end else if (sample.raw_x >= x_max_q) begin
			sel_x = tcc_pkg::SEL_FULL;
		end else begin
			sel_x = tcc_pkg::SEL_QUOT;
		end
		if (sample.raw_y <= y_min_q) begin
			sel_y = tcc_pkg::SEL_ZERO;
		end else if (sample.raw_y >= y_max_q) begin
			sel_y = tcc_pkg::SEL_FULL;
		end else begin
			sel_y = tcc_pkg::SEL_QUOT;
		end
	end

	logic [DENW-1:0] num_x_s1, num_y_s1, den_x_s1, den_y_s1;
	tcc_pkg::side_t  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			num_x_s1      <= num_x;
			num_y_s1      <= num_y;
			den_x_s1      <= den_x;
			den_y_s1      <= den_y;
			side_s1.uncal <= uncal;
			side_s1.sel_x <= sel_x;
			side_s1.sel_y <= sel_y;
		end
	end

	// Stage 2: dividend is 4095 times the offset, formed as a shift and subtract.
	logic [NUMW-1:0] dvd_x_s2, dvd_y_s2;
	logic [DENW-1:0] den_x_s2, den_y_s2;
	tcc_pkg::side_t  side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			dvd_x_s2 <= (NUMW'(num_x_s1) << QW) - NUMW'(num_x_s1);
			dvd_y_s2 <= (NUMW'(num_y_s1) << QW) - NUMW'(num_y_s1);
			den_x_s2 <= den_x_s1;
			den_y_s2 <= den_y_s1;
			side_s2  <= side_s1;
		end
	end

	// Divider stages.
	logic [NUMW-1:0] div_num [2];
	logic [DENW-1:0] div_den [2];

	assign div_num[0] = dvd_x_s2;
	assign div_num[1] = dvd_y_s2;
	assign div_den[0] = den_x_s2;
	assign div_den[1] = den_y_s2;

	tcc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_num    (div_num),
		.in_den    (div_den),
		.in_side   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (rdy_s3),
		.out_quot  (div_quot),
		.out_side  (div_side)
	);

	// Stage 3: apply clamping, inversion and axis swap.
	logic [QW-1:0] ax_x, ax_y, inv_x, inv_y;

	always_comb begin
		case (div_side.sel_x)
			tcc_pkg::SEL_ZERO: ax_x = '0;
			tcc_pkg::SEL_FULL: ax_x = tcc_pkg::FULL_SCALE;
			tcc_pkg::SEL_QUOT: ax_x = div_quot[0];
			default:           ax_x = '0;
		endcase
		case (div_side.sel_y)
			tcc_pkg::SEL_ZERO: ax_y = '0;
			tcc_pkg::SEL_FULL: ax_y = tcc_pkg::FULL_SCALE;
			tcc_pkg::SEL_QUOT: ax_y = div_quot[1];
			default:           ax_y = '0;
		endcase
		inv_x = orient_q[0] ? tcc_pkg::FULL_SCALE - ax_x : ax_x;
		inv_y = orient_q[1] ? tcc_pkg::FULL_SCALE - ax_y : ax_y;
	end

	logic [QW-1:0] nx_s3, ny_s3;
	logic          uncal_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && div_out_valid) begin
			nx_s3    <= orient_q[2] ? inv_y : inv_x;
			ny_s3    <= orient_q[2] ? inv_x : inv_y;
			uncal_s3 <= div_side.uncal;
		end
	end

	// Stage 4: scale to the screen and drop the twelve fraction bits.
	logic [NUMW-1:0] prod_x, prod_y;
	logic [PIXW-1:0] pix_x_s4, pix_y_s4;
	logic            uncal_s4;

	assign prod_x = NUMW'(nx_s3) * NUMW'(scr_w_q);
	assign prod_y = NUMW'(ny_s3) * NUMW'(scr_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			pix_x_s4 <= uncal_s3 ? '0 : prod_x[NUMW-1:QW];
			pix_y_s4 <= uncal_s3 ? '0 : prod_y[NUMW-1:QW];
			uncal_s4 <= uncal_s3;
		end
	end

	assign result.valid        = v_s4;
	assign result.pixel_x      = pix_x_s4;
	assign result.pixel_y      = pix_y_s4;
	assign result.uncalibrated = uncal_s4;

`ifndef SYNTH
	// An uncalibrated result never carries a coordinate.
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.uncalibrated |-> result.pixel_x == '0 && result.pixel_y == '0)
		else $error("uncalibrated result with nonzero pixels");

	// With no result waiting, every stage can advance and sample.ready is high.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("sample stalled while output is empty");

	// An in-range reading has an offset strictly below the span.
	a_offset_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !side_s1.uncal && side_s1.sel_x == tcc_pkg::SEL_QUOT |-> num_x_s1 < den_x_s1)
		else $error("x offset not below span");

	// A stalled output stage keeps its pipeline predecessor's valid bit.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !result.ready && v_s3 |=> v_s3)
		else $error("stage 3 lost its transaction during a stall");
`endif

endmodule
